// ===== hw/rtl/wgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants for the wildcard glob matcher
// Holds the operation codes, the wildcard byte values and the control
// bundle that the top level broadcasts to every matcher cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wgm_pkg;

  // Operation carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } wgm_op_t;

  // Wildcard bytes in a pattern.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  // Control broadcast from the top level to the cell row.
  typedef struct packed {
    logic       restart;    // drop all positions but position zero
    logic       advance;    // step the automaton by one subject byte
    logic       wr_en;      // store a pattern byte at the write pointer
    logic [7:0] char_value; // pattern or subject byte
  } wgm_ctrl_t;

endpackage

// ===== hw/rtl/wgm_cell.sv =====
// ----------------------------------------------------------------------------
// wgm_cell: one pattern position of the matcher
// Holds one pattern byte and the active bit of its position. It takes the
// star skip and the match step from the cell below and hands its own to
// the cell above. Star runs are folded on load, so the skip crosses at
// most one cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wgm_cell
  import wgm_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wgm_ctrl_t        ctrl,
  input  logic [LEN_W-1:0] wr_ptr,
  input  logic [LEN_W-1:0] clen,
  input  logic             skip_in,
  input  logic             fwd_in,
  output logic             skip_out,
  output logic             fwd_out,
  output logic             closed
);

  localparam logic [LEN_W-1:0] MY_POS = LEN_W'(IDX);
  localparam logic RESTART_VAL = (IDX == 0);

  logic [7:0] byte_r;
  logic       act_r;
  logic       act_nxt;
  logic       live;
  logic       is_star;
  logic       hit;

  // Pattern byte store; only read once the position is inside the pattern.
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (wr_ptr == MY_POS)) begin
      byte_r <= ctrl.char_value;
    end
  end

  assign live    = (MY_POS < clen);
  assign is_star = (byte_r == STAR_BYTE);
  assign hit     = (byte_r == ctrl.char_value) || (byte_r == ANY_BYTE);

  // A star below may match empty, which opens this position as well.
  assign closed   = act_r | skip_in;
  assign skip_out = act_r & is_star & live;
  assign fwd_out  = closed & ~is_star & live & hit;

  // Next active bit: a star keeps itself, a match opens the position above.
  always_comb begin
    act_nxt = act_r;
    if (ctrl.restart) begin
      act_nxt = RESTART_VAL;
    end else if (ctrl.advance) begin
      act_nxt = (closed & is_star & live) | fwd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= RESTART_VAL;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

// ===== hw/rtl/wildcard_glob_matcher.sv =====
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: whole-string '*' / '?' pattern matcher
// A pattern is loaded byte by byte into a row of cells, then a subject is
// streamed through; an end transfer reports whether the whole subject matched.
//
//   Channel  Direction  tdata                     tuser
//   in_      slave      [7:0] char_value          [1:0] op
//   out_     master     [0] matched,              none
//                       [1] pattern_too_long
//
// All positions of the cell row step together, so one item is accepted per
// clock while in_tready is high. An end transfer's result is registered and
// appears on out_ the cycle after acceptance.
// Reset needs no clearing pass.
// The input stalls only while a result is held and out_tready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wildcard_glob_matcher
  import wgm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_value
  input  logic [1:0] in_tuser,   // [1:0] op
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] matched, [1] pattern_too_long, [7:2] zero
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_PATTERN);

  logic             accept;
  wgm_op_t          op;
  logic [7:0]       char_value;
  wgm_ctrl_t        ctrl;

  logic [LEN_W-1:0] raw_len_r, raw_len_nxt;
  logic [LEN_W-1:0] clen_r, clen_nxt;
  logic             last_star_r, last_star_nxt;
  logic             ovf_r, ovf_nxt;
  logic             tail_r, tail_nxt;
  logic             store_en;

  logic [MAX_PATTERN:0] skip_c;
  logic [MAX_PATTERN:0] fwd_c;
  logic [MAX_PATTERN:0] closed_vec;
  logic                 match_hit;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_data_r, out_data_nxt;

  // Input transfer and field decode.
  assign in_tready  = out_tready | ~out_valid_r;
  assign accept     = in_tvalid & in_tready;
  assign op         = wgm_op_t'(in_tuser);
  assign char_value = in_tdata;

  // Append: a star right after a stored star adds nothing and is folded away,
  // but it still counts toward the length limit.
  assign store_en = accept && (op == OP_APPEND) && (raw_len_r != FULL_LEN) &&
                    !((char_value == STAR_BYTE) && last_star_r);

  always_comb begin
    ctrl.restart    = accept && (op != OP_SUBJECT);
    ctrl.advance    = accept && (op == OP_SUBJECT);
    ctrl.wr_en      = store_en;
    ctrl.char_value = char_value;
  end

  // Pattern length, folded length and overflow flag.
  always_comb begin
    raw_len_nxt   = raw_len_r;
    clen_nxt      = clen_r;
    last_star_nxt = last_star_r;
    ovf_nxt       = ovf_r;
    if (accept) begin
      case (op)
        OP_CLEAR: begin
          raw_len_nxt   = '0;
          clen_nxt      = '0;
          last_star_nxt = 1'b0;
          ovf_nxt       = 1'b0;
        end
        OP_APPEND: begin
          if (raw_len_r == FULL_LEN) begin
            ovf_nxt = 1'b1;
          end else begin
            raw_len_nxt   = raw_len_r + 1'b1;
            last_star_nxt = (char_value == STAR_BYTE);
            if (store_en) begin
              clen_nxt = clen_r + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Row of matcher cells, one per pattern position.
  assign skip_c[0] = 1'b0;
  assign fwd_c[0]  = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    wgm_cell #(
      .IDX   (i),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .wr_ptr   (clen_r),
      .clen     (clen_r),
      .skip_in  (skip_c[i]),
      .fwd_in   (fwd_c[i]),
      .skip_out (skip_c[i+1]),
      .fwd_out  (fwd_c[i+1]),
      .closed   (closed_vec[i])
    );
  end

  // Position past the last cell; it never holds a star.
  assign closed_vec[MAX_PATTERN] = tail_r | skip_c[MAX_PATTERN];

  always_comb begin
    tail_nxt = tail_r;
    if (ctrl.restart) begin
      tail_nxt = 1'b0;
    end else if (ctrl.advance) begin
      tail_nxt = fwd_c[MAX_PATTERN];
    end
  end

  // The subject matched if the position at the end of the pattern is open and the pattern did not overflow.
  assign match_hit = closed_vec[clen_r] & ~ovf_r;

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept && (op == OP_END)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {ovf_r, match_hit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_len_r   <= '0;
      clen_r      <= '0;
      last_star_r <= 1'b0;
      ovf_r       <= 1'b0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      raw_len_r   <= raw_len_nxt;
      clen_r      <= clen_nxt;
      last_star_r <= last_star_nxt;
      ovf_r       <= ovf_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};

endmodule
